### design/osm_pkg.sv
`default_nettype none

package osm_pkg;

	localparam int CAPACITY = 256;

	localparam int DATA_W = 32;
	localparam int OP_W = 3;
	localparam int IDX_W = 9;
	localparam int OUT_W = 9;
	localparam int ST_W = 2;

	// opcodes
	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_ERASE = 3'd1;
	localparam logic [OP_W-1:0] OP_KTH = 3'd2;
	localparam logic [OP_W-1:0] OP_RANK = 3'd3;
	localparam logic [OP_W-1:0] OP_PRED = 3'd4;
	localparam logic [OP_W-1:0] OP_SUCC = 3'd5;

	// status codes
	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_ABSENT = 2'd2;
	localparam logic [ST_W-1:0] ST_NONE = 2'd3;

	// no-neighbor sentinels
	localparam logic signed [DATA_W-1:0] SENT_POS = 32'sh3f3f3f3f;
	localparam logic signed [DATA_W-1:0] SENT_NEG = 32'shc0c0c0c1;

	// command broadcast to every cell
	typedef struct packed {
		logic cmp_en;
		logic ins_en;
		logic era_en;
	} osm_cmd_t;

endpackage

`default_nettype wire

### design/osm_cell.sv
`default_nettype none

module osm_cell #(
	parameter int CAPACITY = osm_pkg::CAPACITY,
	parameter int IDX = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire osm_pkg::osm_cmd_t cmd,
	input wire logic signed [osm_pkg::DATA_W-1:0] key,
	input wire logic [osm_pkg::IDX_W-1:0] order_index,
	input wire logic [$clog2(CAPACITY+1)-1:0] count,
	input wire logic signed [osm_pkg::DATA_W-1:0] left_value,
	input wire logic left_lt,
	input wire logic left_gt,
	input wire logic signed [osm_pkg::DATA_W-1:0] right_value,
	input wire logic right_lt,
	output logic signed [osm_pkg::DATA_W-1:0] cell_value,
	output logic lt,
	output logic gt,
	output logic eq,
	output logic kth_pick,
	output logic pred_pick,
	output logic succ_pick
);

	logic signed [osm_pkg::DATA_W-1:0] value_q;
	logic lt_q, eq_q, gt_q, kth_q;
	logic valid;
	logic ins_here;

	assign valid = int'(count) > IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
			gt_q <= 1'b0;
			kth_q <= 1'b0;
		end else if (cmd.cmp_en) begin
			lt_q <= valid && (value_q < key);
			eq_q <= valid && (value_q == key);
			gt_q <= valid && (value_q > key);
			kth_q <= int'(order_index) == IDX + 1;
		end
	end

	// first cell not below the key takes the new value
	assign ins_here = !lt_q && left_lt;

	always_ff @(posedge clk) begin
		if (cmd.ins_en && !lt_q) begin
			value_q <= ins_here ? key : left_value;
		end else if (cmd.era_en && !lt_q) begin
			value_q <= right_value;
		end
	end

	assign cell_value = value_q;
	assign lt = lt_q;
	assign gt = gt_q;
	assign eq = eq_q;
	assign kth_pick = kth_q;
	assign pred_pick = lt_q && !right_lt;
	assign succ_pick = gt_q && !left_gt;

endmodule

`default_nettype wire

### design/order_statistic_multiset_top.sv
`default_nettype none

// order-statistic multiset: a sorted row of CAPACITY cells holding signed 32-bit values
// command channel: an operation transfers at a rising edge with start high and busy low;
//   opcode selects insert, erase, kth smallest, rank, predecessor or successor
// result channel: done is high for exactly one cycle with value, rank, element_total,
//   found and status; the receiver cannot stall, so results are never held back
// sequence: an accepted operation passes a compare phase, in which every cell compares
//   the key, then an update phase, which reduces the cell flags and shifts the row;
//   done and the results are registered at the end of the update phase
// a new operation is not taken while one is in flight; busy drops in the cycle in which
//   done is shown, so the next transfer lands at the edge that ends that cycle
// the sequence is set by the compare stage inside each cell followed by the one-hot
//   selection across the row; insert and erase shift every cell not below the key by
//   one place in the same cycle through the neighbor links
// reset: arst_n clears the element count and the sequencer; the cell contents are
//   not cleared, cells at or above the count are masked out of every compare
module order_statistic_multiset_top #(
	parameter int CAPACITY = osm_pkg::CAPACITY
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [osm_pkg::OP_W-1:0] opcode,
	input wire logic signed [osm_pkg::DATA_W-1:0] key,
	input wire logic [osm_pkg::IDX_W-1:0] order_index,
	output logic done,
	output logic signed [osm_pkg::DATA_W-1:0] value,
	output logic [osm_pkg::OUT_W-1:0] rank,
	output logic [osm_pkg::OUT_W-1:0] element_total,
	output logic found,
	output logic [osm_pkg::ST_W-1:0] status
);

	localparam int CW = $clog2(CAPACITY + 1);
	// wide enough for count plus one and for the 9-bit output fields
	localparam int SW = (CW + 1 > osm_pkg::OUT_W) ? CW + 1 : osm_pkg::OUT_W;

	// sequencer codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_CMP = 2'd1;
	localparam logic [1:0] PH_UPD = 2'd2;

	logic [1:0] phase_q;
	logic [osm_pkg::OP_W-1:0] op_q;
	logic signed [osm_pkg::DATA_W-1:0] key_q;
	logic [osm_pkg::IDX_W-1:0] k_q;
	logic [CW-1:0] count_q;

	osm_pkg::osm_cmd_t cmd;

	// cell row signals
	logic signed [osm_pkg::DATA_W-1:0] cell_value [CAPACITY];
	logic [CAPACITY-1:0] cell_lt, cell_gt, cell_eq;
	logic [CAPACITY-1:0] kth_pick, pred_pick, succ_pick;

	// reductions over the row
	logic [CW-1:0] below;
	logic signed [osm_pkg::DATA_W-1:0] kth_val, pred_val, succ_val;
	logic any_eq, has_pred, has_succ, kth_ok, full;

	// next result
	logic signed [osm_pkg::DATA_W-1:0] res_value;
	logic res_found;
	logic [osm_pkg::ST_W-1:0] res_status;
	logic [CW-1:0] count_d;
	logic [SW-1:0] rank_w, total_w;

	logic accept;

	assign accept = start && !busy;
	assign busy = phase_q != PH_IDLE;

	// command register for the item in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= opcode;
			key_q <= key;
			k_q <= order_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			case (phase_q)
				PH_IDLE: if (accept) phase_q <= PH_CMP;
				PH_CMP: phase_q <= PH_UPD;
				PH_UPD: phase_q <= PH_IDLE;
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	// one-hot selects across the row; at most one pick per kind is set
	always_comb begin
		below = '0;
		kth_val = '0;
		pred_val = '0;
		succ_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (pred_pick[i]) below = below | CW'(i + 1);
			if (kth_pick[i]) kth_val = kth_val | cell_value[i];
			if (pred_pick[i]) pred_val = pred_val | cell_value[i];
			if (succ_pick[i]) succ_val = succ_val | cell_value[i];
		end
	end

	assign any_eq = |cell_eq;
	assign has_pred = |pred_pick;
	assign has_succ = |succ_pick;
	assign full = SW'(count_q) == SW'(CAPACITY);
	assign kth_ok = (k_q != '0) && (SW'(k_q) <= SW'(count_q));

	always_comb begin
		res_value = '0;
		res_found = 1'b0;
		res_status = osm_pkg::ST_OK;
		count_d = count_q;
		cmd.cmp_en = phase_q == PH_CMP;
		cmd.ins_en = 1'b0;
		cmd.era_en = 1'b0;
		case (op_q)
			osm_pkg::OP_INSERT: begin
				if (full) begin
					res_status = osm_pkg::ST_FULL;
				end else begin
					cmd.ins_en = phase_q == PH_UPD;
					count_d = count_q + CW'(1);
				end
			end
			osm_pkg::OP_ERASE: begin
				if (any_eq) begin
					cmd.era_en = phase_q == PH_UPD;
					count_d = count_q - CW'(1);
					res_found = 1'b1;
				end else begin
					res_status = osm_pkg::ST_ABSENT;
				end
			end
			osm_pkg::OP_KTH: begin
				if (kth_ok) begin
					res_value = kth_val;
					res_found = 1'b1;
				end else begin
					res_status = osm_pkg::ST_NONE;
				end
			end
			osm_pkg::OP_RANK: begin
				res_found = any_eq;
			end
			osm_pkg::OP_PRED: begin
				if (has_pred) begin
					res_value = pred_val;
					res_found = 1'b1;
				end else begin
					res_value = osm_pkg::SENT_NEG;
					res_status = osm_pkg::ST_NONE;
				end
			end
			osm_pkg::OP_SUCC: begin
				if (has_succ) begin
					res_value = succ_val;
					res_found = 1'b1;
				end else begin
					res_value = osm_pkg::SENT_POS;
					res_status = osm_pkg::ST_NONE;
				end
			end
			default: begin
				// unused opcodes leave the store alone
			end
		endcase
	end

	assign rank_w = SW'(below) + SW'(1);
	assign total_w = SW'(count_d);

	// element count and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done <= 1'b0;
		end else begin
			done <= phase_q == PH_UPD;
			if (phase_q == PH_UPD) count_q <= count_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (phase_q == PH_UPD) begin
			value <= res_value;
			rank <= rank_w[osm_pkg::OUT_W-1:0];
			element_total <= total_w[osm_pkg::OUT_W-1:0];
			found <= res_found;
			status <= res_status;
		end
	end

	// the row of cells, each linked to its two neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [osm_pkg::DATA_W-1:0] lv, rv;
		logic llt, lgt, rlt;

		if (i == 0) begin : g_first
			assign lv = key_q;
			assign llt = 1'b1;
			assign lgt = 1'b0;
		end else begin : g_mid_l
			assign lv = cell_value[i-1];
			assign llt = cell_lt[i-1];
			assign lgt = cell_gt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rv = cell_value[i];
			assign rlt = 1'b0;
		end else begin : g_mid_r
			assign rv = cell_value[i+1];
			assign rlt = cell_lt[i+1];
		end

		osm_cell #(
			.CAPACITY(CAPACITY),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.key(key_q),
			.order_index(k_q),
			.count(count_q),
			.left_value(lv),
			.left_lt(llt),
			.left_gt(lgt),
			.right_value(rv),
			.right_lt(rlt),
			.cell_value(cell_value[i]),
			.lt(cell_lt[i]),
			.gt(cell_gt[i]),
			.eq(cell_eq[i]),
			.kth_pick(kth_pick[i]),
			.pred_pick(pred_pick[i]),
			.succ_pick(succ_pick[i])
		);
	end

	// accepted command always enters the compare phase
	a_accept_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> phase_q == PH_CMP)
		else $error("accepted command did not enter compare");

	// every update phase follows a compare phase and produces exactly one done strobe
	a_upd_done: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_UPD) == $past(phase_q == PH_CMP))
		else $error("update phase without compare phase");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(done))
		else $error("done strobe held for more than one cycle");

	// count never exceeds the row length
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(count_q) <= SW'(CAPACITY))
		else $error("element count above capacity");

	// sorted row gives at most one predecessor and at most one successor candidate
	a_pick_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_UPD |-> $onehot0(pred_pick) && $onehot0(succ_pick))
		else $error("row not sorted: multiple neighbor picks");

endmodule

`default_nettype wire
